// ----- sv/ppmfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppmfd_pkg: shared types and constants of the PPM frame decoder
// Operation codes, register indexes, payload structs and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

   localparam logic [1:0] OP_CAPTURE  = 2'd0;
   localparam logic [1:0] OP_ROLLOVER = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   localparam int unsigned REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SYNC_MIN      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SYNC_MAX      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ROLLOVER_STEP = 3'd4;

   localparam int unsigned ADDR_W = 5;

   localparam logic [15:0] PULSE_MIN_RESET     = 16'd900;
   localparam logic [15:0] PULSE_MAX_RESET     = 16'd2100;
   localparam logic [31:0] SYNC_MIN_RESET      = 32'd2700;
   localparam logic [31:0] SYNC_MAX_RESET      = 32'd20000;
   localparam logic [16:0] ROLLOVER_STEP_RESET = 17'd20000;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] capture_count;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [2:0]  channel_number;
      logic [15:0] channel_width;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pulse_min;
      logic [15:0] pulse_max;
      logic [31:0] sync_min;
      logic [31:0] sync_max;
      logic [16:0] rollover_step;
   } cfg_type;

   typedef struct packed {
      logic load_now;    // capture accepted: now = count + time base
      logic roll;        // overflow accepted: advance time base
      logic start_read;  // read accepted: rewind read index
      logic calc_width;  // width = now - previous edge
      logic decode;      // run the channel / sync decision
      logic emit;        // load one result into the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a result this cycle
      logic emit_last;   // the next result ends the read
   } status_type;

endpackage
`default_nettype wire

// ----- sv/ppmfd_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppmfd_csr: configuration registers
// APB-style register file for the decode windows and the rollover step.
// ----------------------------------------------------------------------------
module ppmfd_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ppmfd_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready,
   output ppmfd_pkg::cfg_type                 cfg
);

   ppmfd_pkg::cfg_type cfg_ff;
   logic [ppmfd_pkg::REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign reg_idx = paddr[ppmfd_pkg::ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min     <= ppmfd_pkg::PULSE_MIN_RESET;
         cfg_ff.pulse_max     <= ppmfd_pkg::PULSE_MAX_RESET;
         cfg_ff.sync_min      <= ppmfd_pkg::SYNC_MIN_RESET;
         cfg_ff.sync_max      <= ppmfd_pkg::SYNC_MAX_RESET;
         cfg_ff.rollover_step <= ppmfd_pkg::ROLLOVER_STEP_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            ppmfd_pkg::REG_PULSE_MIN:     cfg_ff.pulse_min     <= pwdata[15:0];
            ppmfd_pkg::REG_PULSE_MAX:     cfg_ff.pulse_max     <= pwdata[15:0];
            ppmfd_pkg::REG_SYNC_MIN:      cfg_ff.sync_min      <= pwdata;
            ppmfd_pkg::REG_SYNC_MAX:      cfg_ff.sync_max      <= pwdata;
            ppmfd_pkg::REG_ROLLOVER_STEP: cfg_ff.rollover_step <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ppmfd_pkg::REG_PULSE_MIN:     prdata = {16'd0, cfg_ff.pulse_min};
         ppmfd_pkg::REG_PULSE_MAX:     prdata = {16'd0, cfg_ff.pulse_max};
         ppmfd_pkg::REG_SYNC_MIN:      prdata = cfg_ff.sync_min;
         ppmfd_pkg::REG_SYNC_MAX:      prdata = cfg_ff.sync_max;
         ppmfd_pkg::REG_ROLLOVER_STEP: prdata = {15'd0, cfg_ff.rollover_step};
         default:                      prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/ppmfd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppmfd_ctrl: sequencing state machine
// Accepts one request at a time and steps the datapath through capture
// decode, a time base rollover or the result sweep of a read.
// ----------------------------------------------------------------------------
module ppmfd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_operation,
   input  ppmfd_pkg::status_type      status,
   output ppmfd_pkg::cmd_type         cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WIDTH  = 2'd1;
   localparam logic [1:0] S_DECODE = 2'd2;
   localparam logic [1:0] S_READ   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  ppmfd_pkg::OP_CAPTURE: begin
                     cmd.load_now = 1'b1;
                     state_in     = S_WIDTH;
                  end
                  ppmfd_pkg::OP_ROLLOVER: cmd.roll = 1'b1;
                  ppmfd_pkg::OP_READ: begin
                     cmd.start_read = 1'b1;
                     state_in       = S_READ;
                  end
                  default: ;  // unused code: dropped
               endcase
            end
         end
         S_WIDTH: begin
            cmd.calc_width = 1'b1;
            state_in       = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_IDLE;
         end
         S_READ: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/ppmfd_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppmfd_dp: decode datapath
// Time base, edge timing, channel window checks, two banks of pulse
// storage swapped on a valid frame, and the result output register.
// ----------------------------------------------------------------------------
module ppmfd_dp #(
   parameter int unsigned CHANNELS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           req_capture_count,
   input  ppmfd_pkg::cfg_type         cfg,
   input  ppmfd_pkg::cmd_type         cmd,
   output ppmfd_pkg::status_type      status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ppmfd_pkg::rsp_type         rsp_data
);

   localparam int unsigned POS_W = $clog2(CHANNELS + 1);
   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [POS_W-1:0] POS_FULL = POS_W'(CHANNELS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

   logic [31:0]      time_base_ff;
   logic [31:0]      prev_edge_ff;
   logic [31:0]      now_ff;
   logic [31:0]      width_ff;
   logic [POS_W-1:0] pos_ff;
   logic             complete_ff;
   logic             frame_ready_ff;
   logic             wbank_ff;       // bank under fill; the other holds the frame
   logic [IDX_W-1:0] idx_ff;
   logic [15:0]      store_ff [2][CHANNELS];
   logic             rsp_valid_ff;
   ppmfd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic in_pulse, in_sync, at_sync, frame_done;
   logic [POS_W-1:0] pos_next;

   assign in_pulse   = (width_ff > {16'd0, cfg.pulse_min}) &&
                       (width_ff < {16'd0, cfg.pulse_max});
   assign in_sync    = (width_ff > cfg.sync_min) && (width_ff < cfg.sync_max);
   assign at_sync    = (pos_ff >= POS_FULL);
   assign pos_next   = pos_ff + POS_W'(1);
   assign frame_done = cmd.decode & at_sync & in_sync & complete_ff;

   assign status.out_free  = ~rsp_valid_ff | rsp_ready;
   assign status.emit_last = ~frame_ready_ff | (idx_ff == IDX_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff   <= 32'd0;
         prev_edge_ff   <= 32'd0;
         pos_ff         <= '0;
         complete_ff    <= 1'b0;
         frame_ready_ff <= 1'b0;
         wbank_ff       <= 1'b0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.roll) time_base_ff <= time_base_ff + {15'd0, cfg.rollover_step};
         if (cmd.calc_width) prev_edge_ff <= now_ff;
         if (cmd.decode) begin
            if (at_sync) begin
               if (in_sync) begin
                  pos_ff      <= '0;
                  complete_ff <= 1'b0;
               end else begin
                  complete_ff <= 1'b0;
               end
            end else if (in_pulse) begin
               pos_ff <= pos_next;
               if (pos_next == POS_FULL) complete_ff <= 1'b1;
            end else begin
               pos_ff      <= POS_FULL;
               complete_ff <= 1'b0;
            end
         end
         if (frame_done) begin
            wbank_ff       <= ~wbank_ff;
            frame_ready_ff <= 1'b1;
         end
         if (cmd.start_read) idx_ff <= '0;
         if (cmd.emit) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (status.emit_last) frame_ready_ff <= 1'b0;
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_data_in.success        = frame_ready_ff;
      rsp_data_in.channel_number = frame_ready_ff ? 3'(idx_ff) : 3'd0;
      rsp_data_in.channel_width  = frame_ready_ff ? store_ff[~wbank_ff][idx_ff] : 16'd0;
      rsp_data_in.last           = status.emit_last;
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.load_now) now_ff <= {16'd0, req_capture_count} + time_base_ff;
      if (cmd.calc_width) width_ff <= now_ff - prev_edge_ff;
      if (cmd.decode && !at_sync && in_pulse)
         store_ff[wbank_ff][pos_ff[IDX_W-1:0]] <= width_ff[15:0];
      if (cmd.emit) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_FULL)
      else $error("channel position beyond channel count");

   a_complete_full: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> (pos_ff == POS_FULL))
      else $error("frame marked complete with channels missing");

   a_ready_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.emit_last) |=> !frame_ready_ff)
      else $error("frame still ready after final result of a read");

   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.success) |-> rsp_data_ff.last)
      else $error("failure result not marked last");

endmodule
`default_nettype wire

// ----- sv/ppm_frame_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_frame_decoder: RC PPM pulse train decoder
// Times capture edges against a rollover-extended time base, checks each
// gap against the channel and sync windows and hands out complete frames.
// ----------------------------------------------------------------------------
//  channel | ports                        | transfer
//  --------+------------------------------+--------------------------------------
//  request | req_valid/req_ready/req_data | capture, overflow or read command
//  result  | rsp_valid/rsp_ready/rsp_data | one channel of a frame, or a failure
//  config  | psel/penable/pwrite/paddr... | register write/read, pready always 1
//
//  A capture steps the block through time add, width subtract and window
//  decision; an overflow ends on acceptance; a read emits CHANNELS results
//  (one failure without a frame), paced by the single result output register.
//  A valid frame swaps the two pulse banks instead of copying them.
//  Reset is synchronous; it clears the time base, edge time, position and
//  frame flags; pulse banks are undefined until written.
//  A stalled result channel holds the output register and pauses the read.
//  Overflow and unused operation codes produce no result.
// ----------------------------------------------------------------------------
module ppm_frame_decoder #(
   parameter int unsigned CHANNELS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  ppmfd_pkg::req_type                 req_data,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output ppmfd_pkg::rsp_type                 rsp_data,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ppmfd_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);

   ppmfd_pkg::cfg_type    cfg;
   ppmfd_pkg::cmd_type    cmd;
   ppmfd_pkg::status_type status;

   // register file
   ppmfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: owns req_ready, drives one command group per cycle
   ppmfd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_data.operation),
      .status        (status),
      .cmd           (cmd)
   );

   // timing, windows, pulse banks and result register
   ppmfd_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_capture_count (req_data.capture_count),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data)
   );

endmodule
`default_nettype wire
